/* hw/rtl/spma_pkg.sv */
// ----------------------------------------------------------------------------
// spma_pkg
// shared constants, term record, opcodes and controller state type for the
// sparse polynomial term merge adder
// ----------------------------------------------------------------------------
`default_nettype none

package spma_pkg;

    localparam int LIST_DEPTH    = 16;
    localparam int EXPONENT_BITS = 8;
    localparam int COEFF_BITS    = 16;
    localparam int OUT_LIMIT     = 32;

    localparam int ADDR_BITS = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);
    localparam int NUM_BITS  = $clog2(OUT_LIMIT + 1);
    localparam int SUM_BITS  = COEFF_BITS + 1;
    localparam int OP_BITS   = 2;

    localparam logic [OP_BITS-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_BITS-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MERGE  = 2'd2;

    typedef struct packed {
        logic [EXPONENT_BITS-1:0] xe;
        logic [EXPONENT_BITS-1:0] ye;
        logic [COEFF_BITS-1:0]    co;
    } term_t;

    localparam int TERM_BITS = $bits(term_t);

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic [ADDR_BITS-1:0] raddr;
        term_t                wdata;
    } ram_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/spma_term_ram.sv */
// ----------------------------------------------------------------------------
// spma_term_ram
// single write port, single read port synchronous ram, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module spma_term_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [ABITS-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/spma_ctrl.sv */
// ----------------------------------------------------------------------------
// spma_ctrl
// list counters, load handling and the two-list merge sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module spma_ctrl
    import spma_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [OP_BITS-1:0]         operation,
    input  wire logic [EXPONENT_BITS-1:0]   x_exponent,
    input  wire logic [EXPONENT_BITS-1:0]   y_exponent,
    input  wire logic signed [COEFF_BITS-1:0] coefficient,
    output ram_req_t                        req_a,
    output ram_req_t                        req_b,
    input  wire term_t                      rd_a,
    input  wire term_t                      rd_b,
    output logic                            result_strobe,
    output logic [EXPONENT_BITS-1:0]        x_exponent_out,
    output logic [EXPONENT_BITS-1:0]        y_exponent_out,
    output logic signed [SUM_BITS-1:0]      sum_coefficient,
    output logic                            last_term,
    output logic                            empty_sum,
    output logic                            terms_dropped
);

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_a_reg, cnt_a_next;
    logic [CNT_BITS-1:0]   cnt_b_reg, cnt_b_next;
    logic [CNT_BITS-1:0]   ia_reg, ia_next;
    logic [CNT_BITS-1:0]   ib_reg, ib_next;
    logic [NUM_BITS-1:0]   n_reg, n_next;
    logic                  ovf_reg, ovf_next;
    logic                  strobe_reg, strobe_next;

    logic [EXPONENT_BITS-1:0] xo_reg, xo_next;
    logic [EXPONENT_BITS-1:0] yo_reg, yo_next;
    logic [SUM_BITS-1:0]      sum_reg, sum_next;
    logic                     last_reg, last_next;
    logic                     empty_reg, empty_next;
    logic                     drop_reg, drop_next;

    term_t                 load_term;
    logic                  a_valid, b_valid, a_first, take_a, take_b, more;
    logic [SUM_BITS-1:0]   ext_a, ext_b;
    logic [CNT_BITS-1:0]   ia_inc, ib_inc;
    logic [NUM_BITS-1:0]   n_inc;

    assign load_term = '{xe: x_exponent, ye: y_exponent, co: coefficient};

    assign req_a.we    = (state_reg == ST_IDLE) && start && (operation == OP_LOAD_A)
                         && (cnt_a_reg < CNT_BITS'(LIST_DEPTH));
    assign req_a.waddr = cnt_a_reg[ADDR_BITS-1:0];
    assign req_a.raddr = ia_reg[ADDR_BITS-1:0];
    assign req_a.wdata = load_term;
    assign req_b.we    = (state_reg == ST_IDLE) && start && (operation == OP_LOAD_B)
                         && (cnt_b_reg < CNT_BITS'(LIST_DEPTH));
    assign req_b.waddr = cnt_b_reg[ADDR_BITS-1:0];
    assign req_b.raddr = ib_reg[ADDR_BITS-1:0];
    assign req_b.wdata = load_term;

    // head selection, keys compare as {x, y}
    assign a_valid = ia_reg < cnt_a_reg;
    assign b_valid = ib_reg < cnt_b_reg;
    assign a_first = {rd_a.xe, rd_a.ye} > {rd_b.xe, rd_b.ye};
    assign take_a  = a_valid && (!b_valid || a_first || ({rd_a.xe, rd_a.ye} == {rd_b.xe, rd_b.ye}));
    assign take_b  = b_valid && (!a_valid || !a_first);
    assign ext_a   = take_a ? {rd_a.co[COEFF_BITS-1], rd_a.co} : '0;
    assign ext_b   = take_b ? {rd_b.co[COEFF_BITS-1], rd_b.co} : '0;
    assign ia_inc  = ia_reg + CNT_BITS'(take_a);
    assign ib_inc  = ib_reg + CNT_BITS'(take_b);
    assign n_inc   = n_reg + NUM_BITS'(1);
    assign more    = ((ia_inc < cnt_a_reg) || (ib_inc < cnt_b_reg))
                     && (n_inc < NUM_BITS'(OUT_LIMIT));

    always_comb
    begin
        state_next  = state_reg;
        cnt_a_next  = cnt_a_reg;
        cnt_b_next  = cnt_b_reg;
        ia_next     = ia_reg;
        ib_next     = ib_reg;
        n_next      = n_reg;
        ovf_next    = ovf_reg;
        strobe_next = 1'b0;
        xo_next     = xo_reg;
        yo_next     = yo_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;
        drop_next   = drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_LOAD_A:
                        begin
                            if (req_a.we)
                                cnt_a_next = cnt_a_reg + CNT_BITS'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        OP_LOAD_B:
                        begin
                            if (req_b.we)
                                cnt_b_next = cnt_b_reg + CNT_BITS'(1);
                            else
                                ovf_next = 1'b1;
                        end
                        OP_MERGE:
                        begin
                            if ((cnt_a_reg == '0) && (cnt_b_reg == '0))
                            begin
                                strobe_next = 1'b1;
                                xo_next     = '0;
                                yo_next     = '0;
                                sum_next    = '0;
                                last_next   = 1'b1;
                                empty_next  = 1'b1;
                                drop_next   = ovf_reg;
                                ovf_next    = 1'b0;
                            end
                            else
                            begin
                                ia_next    = '0;
                                ib_next    = '0;
                                n_next     = '0;
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ia_next     = ia_inc;
                ib_next     = ib_inc;
                n_next      = n_inc;
                strobe_next = 1'b1;
                xo_next     = take_a ? rd_a.xe : rd_b.xe;
                yo_next     = take_a ? rd_a.ye : rd_b.ye;
                sum_next    = ext_a + ext_b;
                last_next   = !more;
                empty_next  = 1'b0;
                drop_next   = ovf_reg;
                if (more)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_a_reg  <= '0;
            cnt_b_reg  <= '0;
            ia_reg     <= '0;
            ib_reg     <= '0;
            n_reg      <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_a_reg  <= cnt_a_next;
            cnt_b_reg  <= cnt_b_next;
            ia_reg     <= ia_next;
            ib_reg     <= ib_next;
            n_reg      <= n_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xo_reg    <= xo_next;
        yo_reg    <= yo_next;
        sum_reg   <= sum_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        drop_reg  <= drop_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result_strobe   = strobe_reg;
    assign x_exponent_out  = xo_reg;
    assign y_exponent_out  = yo_reg;
    assign sum_coefficient = sum_reg;
    assign last_term       = last_reg;
    assign empty_sum       = empty_reg;
    assign terms_dropped   = drop_reg;

endmodule

`default_nettype wire

/* hw/rtl/sparse_polynomial_term_merge_adder_top.sv */
// ----------------------------------------------------------------------------
// sparse_polynomial_term_merge_adder_top
// loads two sorted term lists into memories and merges them into their sum
//
//   channel   handshake              payload
//   command   start / busy           operation, x_exponent, y_exponent,
//                                    coefficient
//   result    result_strobe          x_exponent_out, y_exponent_out,
//                                    sum_coefficient, last_term, empty_sum,
//                                    terms_dropped
//
// a load leaves busy low
// each term that a merge emits passes a list memory read state and then a
// compare and add state; busy is high until the last term is computed
// a merge of two empty lists emits one term and leaves busy low
// each result is registered and shows in the cycle after it is computed, for one cycle
// reset clears the list counts and the dropped-term flag, memories are not
// cleared; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_term_merge_adder_top
    import spma_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [OP_BITS-1:0]           operation,
    input  wire logic [EXPONENT_BITS-1:0]     x_exponent,
    input  wire logic [EXPONENT_BITS-1:0]     y_exponent,
    input  wire logic signed [COEFF_BITS-1:0] coefficient,
    output logic                              result_strobe,
    output logic [EXPONENT_BITS-1:0]          x_exponent_out,
    output logic [EXPONENT_BITS-1:0]          y_exponent_out,
    output logic signed [SUM_BITS-1:0]        sum_coefficient,
    output logic                              last_term,
    output logic                              empty_sum,
    output logic                              terms_dropped
);

    ram_req_t             req_a, req_b;
    logic [TERM_BITS-1:0] rdata_a, rdata_b;

    spma_term_ram #(
        .WIDTH (TERM_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_list_a (
        .clk   (clk),
        .we    (req_a.we),
        .waddr (req_a.waddr),
        .wdata (req_a.wdata),
        .raddr (req_a.raddr),
        .rdata (rdata_a)
    );

    spma_term_ram #(
        .WIDTH (TERM_BITS),
        .DEPTH (LIST_DEPTH)
    ) u_list_b (
        .clk   (clk),
        .we    (req_b.we),
        .waddr (req_b.waddr),
        .wdata (req_b.wdata),
        .raddr (req_b.raddr),
        .rdata (rdata_b)
    );

    spma_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .x_exponent      (x_exponent),
        .y_exponent      (y_exponent),
        .coefficient     (coefficient),
        .req_a           (req_a),
        .req_b           (req_b),
        .rd_a            (term_t'(rdata_a)),
        .rd_b            (term_t'(rdata_b)),
        .result_strobe   (result_strobe),
        .x_exponent_out  (x_exponent_out),
        .y_exponent_out  (y_exponent_out),
        .sum_coefficient (sum_coefficient),
        .last_term       (last_term),
        .empty_sum       (empty_sum),
        .terms_dropped   (terms_dropped)
    );

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the sparse polynomial term merge adder: directed and random
// load/merge sequences, with an in-bench predictor of the merged sum terms and
// a field-by-field check of every emitted result term
// ----------------------------------------------------------------------------
module tb_top;
    import spma_pkg::*;

    localparam logic [OP_BITS-1:0] OP_IGNORED = 2'd3;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int NUM_PHASES = 4;

    typedef struct {
        logic [OP_BITS-1:0]           op;
        logic [EXPONENT_BITS-1:0]     xe;
        logic [EXPONENT_BITS-1:0]     ye;
        logic signed [COEFF_BITS-1:0] co;
    } command_t;

    typedef struct {
        logic [EXPONENT_BITS-1:0]   xe;
        logic [EXPONENT_BITS-1:0]   ye;
        logic signed [SUM_BITS-1:0] co;
        logic                       last;
        logic                       empty;
        logic                       dropped;
    } sum_term_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [OP_BITS-1:0]           operation = '0;
    logic [EXPONENT_BITS-1:0]     x_exponent = '0;
    logic [EXPONENT_BITS-1:0]     y_exponent = '0;
    logic signed [COEFF_BITS-1:0] coefficient = '0;
    logic                         busy;
    logic                         result_strobe;
    logic [EXPONENT_BITS-1:0]     x_exponent_out;
    logic [EXPONENT_BITS-1:0]     y_exponent_out;
    logic signed [SUM_BITS-1:0]   sum_coefficient;
    logic                         last_term;
    logic                         empty_sum;
    logic                         terms_dropped;

    command_t  cmd_queue[$];
    sum_term_t expected_sum_terms[$];
    logic      cmd_taken = 1'b0;
    int        sender_idle_pct = 0;
    int        cmds_queued = 0;
    int        cmds_accepted = 0;
    int        error_count = 0;
    int        merges_seen = 0;
    int        dropped_merges = 0;
    int        results_checked = 0;

    // predictor state
    term_t a_terms[LIST_DEPTH];
    term_t b_terms[LIST_DEPTH];
    int    a_len = 0;
    int    b_len = 0;
    bit    overflow_pending = 1'b0;

    sparse_polynomial_term_merge_adder_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .x_exponent      (x_exponent),
        .y_exponent      (y_exponent),
        .coefficient     (coefficient),
        .result_strobe   (result_strobe),
        .x_exponent_out  (x_exponent_out),
        .y_exponent_out  (y_exponent_out),
        .sum_coefficient (sum_coefficient),
        .last_term       (last_term),
        .empty_sum       (empty_sum),
        .terms_dropped   (terms_dropped)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(string msg);
        error_count++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic signed [31:0] got,
                               logic signed [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic void store_term(bit to_b, logic [EXPONENT_BITS-1:0] xe,
                                       logic [EXPONENT_BITS-1:0] ye,
                                       logic [COEFF_BITS-1:0] co);
        term_t t;
        t.xe = xe;
        t.ye = ye;
        t.co = co;
        if (!to_b && a_len < LIST_DEPTH)
        begin
            a_terms[a_len] = t;
            a_len++;
        end
        else if (to_b && b_len < LIST_DEPTH)
        begin
            b_terms[b_len] = t;
            b_len++;
        end
        else
            overflow_pending = 1'b1;
    endfunction

    function automatic void merge_lists();
        int        ia;
        int        ib;
        int        n;
        bit        take_a;
        bit        take_b;
        sum_term_t t;
        ia = 0;
        ib = 0;
        n = 0;
        merges_seen++;
        if (overflow_pending)
            dropped_merges++;
        if (a_len == 0 && b_len == 0)
        begin
            t.xe = '0;
            t.ye = '0;
            t.co = '0;
            t.last = 1'b1;
            t.empty = 1'b1;
            t.dropped = overflow_pending;
            expected_sum_terms.push_back(t);
        end
        else
        begin
            while ((ia < a_len || ib < b_len) && n < OUT_LIMIT)
            begin
                if (ia >= a_len)
                begin
                    take_a = 1'b0;
                    take_b = 1'b1;
                end
                else if (ib >= b_len)
                begin
                    take_a = 1'b1;
                    take_b = 1'b0;
                end
                else if (a_terms[ia].xe != b_terms[ib].xe)
                begin
                    take_a = a_terms[ia].xe > b_terms[ib].xe;
                    take_b = !take_a;
                end
                else if (a_terms[ia].ye != b_terms[ib].ye)
                begin
                    take_a = a_terms[ia].ye > b_terms[ib].ye;
                    take_b = !take_a;
                end
                else
                begin
                    take_a = 1'b1;
                    take_b = 1'b1;
                end
                if (take_a && take_b)
                    t.co = $signed(a_terms[ia].co) + $signed(b_terms[ib].co);
                else if (take_a)
                    t.co = $signed(a_terms[ia].co);
                else
                    t.co = $signed(b_terms[ib].co);
                t.xe = take_a ? a_terms[ia].xe : b_terms[ib].xe;
                t.ye = take_a ? a_terms[ia].ye : b_terms[ib].ye;
                if (take_a)
                    ia++;
                if (take_b)
                    ib++;
                n++;
                t.last = !((ia < a_len || ib < b_len) && n < OUT_LIMIT);
                t.empty = 1'b0;
                t.dropped = overflow_pending;
                expected_sum_terms.push_back(t);
            end
        end
        a_len = 0;
        b_len = 0;
        overflow_pending = 1'b0;
    endfunction

    function automatic void apply_command(logic [OP_BITS-1:0] op,
                                          logic [EXPONENT_BITS-1:0] xe,
                                          logic [EXPONENT_BITS-1:0] ye,
                                          logic [COEFF_BITS-1:0] co);
        case (op)
            OP_LOAD_A: store_term(1'b0, xe, ye, co);
            OP_LOAD_B: store_term(1'b1, xe, ye, co);
            OP_MERGE:  merge_lists();
            default:   ;
        endcase
    endfunction

    function automatic void push_cmd(logic [OP_BITS-1:0] op, logic [EXPONENT_BITS-1:0] xe,
                                     logic [EXPONENT_BITS-1:0] ye,
                                     logic signed [COEFF_BITS-1:0] co);
        command_t c;
        c.op = op;
        c.xe = xe;
        c.ye = ye;
        c.co = co;
        cmd_queue.push_back(c);
        cmds_queued++;
    endfunction

    // one load/merge sequence with random content, returns the count of
    // non-ignored transactions queued
    function automatic int queue_merge_sequence();
        logic [15:0]                  keys[32];
        logic [15:0]                  k;
        logic signed [COEFF_BITS-1:0] co;
        command_t                     a_cmds[$];
        command_t                     b_cmds[$];
        command_t                     c;
        int                           num_keys;
        int                           j;
        int                           pick_pct;
        int                           queued;
        bit                           unsorted;
        bit                           narrow;
        bit                           from_a;
        queued = 0;
        num_keys = ($urandom_range(9) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 12);
        unsorted = $urandom_range(7) == 0;
        narrow = $urandom_range(3) == 0;
        for (int i = 0; i < num_keys; i++)
        begin
            k = narrow ? {6'd0, 2'($urandom_range(3)), 6'd0, 2'($urandom_range(3))}
                       : 16'($urandom);
            j = i;
            if (!unsorted)
                while (j > 0 && keys[j-1] < k)
                begin
                    keys[j] = keys[j-1];
                    j--;
                end
            keys[j] = k;
        end
        pick_pct = $urandom_range(30, 90);
        for (int i = 0; i < num_keys; i++)
            for (int s = 0; s < 2; s++)
                if ($urandom_range(99) < pick_pct)
                begin
                    case ($urandom_range(9))
                        0:       co = 16'sh7fff;
                        1:       co = 16'sh8000;
                        2:       co = '0;
                        default: co = 16'($urandom);
                    endcase
                    c.op = (s == 0) ? OP_LOAD_A : OP_LOAD_B;
                    c.xe = keys[i][15:8];
                    c.ye = keys[i][7:0];
                    c.co = co;
                    if (s == 0)
                        a_cmds.push_back(c);
                    else
                        b_cmds.push_back(c);
                end
        while (a_cmds.size() != 0 || b_cmds.size() != 0)
        begin
            if ($urandom_range(29) == 0)
                push_cmd(OP_IGNORED, 8'($urandom), 8'($urandom), 16'($urandom));
            from_a = (b_cmds.size() == 0) || (a_cmds.size() != 0 && $urandom_range(1) == 0);
            c = from_a ? a_cmds.pop_front() : b_cmds.pop_front();
            push_cmd(c.op, c.xe, c.ye, c.co);
            queued++;
        end
        // occasionally leave the lists loaded so the next sequence appends
        if ($urandom_range(9) != 0)
        begin
            push_cmd(OP_MERGE, 8'($urandom), 8'($urandom), 16'($urandom));
            queued++;
        end
        return queued;
    endfunction

    // driver
    always @(negedge clk)
    begin : drive_cmd
        command_t c;
        if (rst_n && (!start || cmd_taken))
        begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
            begin
                c = cmd_queue.pop_front();
                operation <= c.op;
                x_exponent <= c.xe;
                y_exponent <= c.ye;
                coefficient <= c.co;
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin : watch_ports
        sum_term_t want;
        cmd_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                if (expected_sum_terms.size() == 0)
                    report_mismatch($sformatf("unexpected result term x=%0d y=%0d co=%0d",
                                              x_exponent_out, y_exponent_out,
                                              sum_coefficient));
                else
                begin
                    want = expected_sum_terms.pop_front();
                    results_checked++;
                    check_field("x_exponent_out", x_exponent_out, want.xe);
                    check_field("y_exponent_out", y_exponent_out, want.ye);
                    check_field("sum_coefficient", sum_coefficient, want.co);
                    check_field("last_term", last_term, want.last);
                    check_field("empty_sum", empty_sum, want.empty);
                    check_field("terms_dropped", terms_dropped, want.dropped);
                end
            end
            if (start && !busy)
            begin
                cmds_accepted++;
                apply_command(operation, x_exponent, y_exponent, coefficient);
            end
        end
    end

    initial
    begin
        int phase_items;
        int idle_by_phase[NUM_PHASES];
        idle_by_phase = '{0, 77, 0, 37};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty merge
        push_cmd(OP_MERGE, 8'd0, 8'd0, 16'sd0);
        // extreme exponents and coefficients, a zero sum, an ignored opcode
        push_cmd(OP_LOAD_A, 8'd255, 8'd255, 16'sh7fff);
        push_cmd(OP_LOAD_B, 8'd255, 8'd255, 16'sh7fff);
        push_cmd(OP_LOAD_B, 8'd128, 8'd1, -16'sd1);
        push_cmd(OP_LOAD_A, 8'd7, 8'd7, 16'sd100);
        push_cmd(OP_LOAD_B, 8'd7, 8'd7, -16'sd100);
        push_cmd(OP_IGNORED, 8'hff, 8'hff, 16'shffff);
        push_cmd(OP_LOAD_A, 8'd0, 8'd0, 16'sh8000);
        push_cmd(OP_LOAD_B, 8'd0, 8'd0, 16'sh8000);
        push_cmd(OP_MERGE, 8'd0, 8'd0, 16'sd0);
        // unsorted list with a duplicate term
        push_cmd(OP_LOAD_A, 8'd1, 8'd2, 16'sd5);
        push_cmd(OP_LOAD_A, 8'd3, 8'd4, 16'sd6);
        push_cmd(OP_LOAD_A, 8'd3, 8'd4, -16'sd7);
        push_cmd(OP_LOAD_B, 8'd3, 8'd4, 16'sd1);
        push_cmd(OP_MERGE, 8'd0, 8'd0, 16'sd0);
        // only list b loaded
        push_cmd(OP_LOAD_B, 8'd10, 8'd0, 16'sh1234);
        push_cmd(OP_MERGE, 8'd0, 8'd0, 16'sd0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            sender_idle_pct = idle_by_phase[p];
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                phase_items += queue_merge_sequence();
            while (cmds_accepted < cmds_queued)
                @(posedge clk);
        end
        push_cmd(OP_MERGE, 8'd0, 8'd0, 16'sd0);
        while (cmds_accepted < cmds_queued || expected_sum_terms.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("summary: %0d transactions accepted, %0d merges (%0d with dropped loads)",
                 cmds_accepted, merges_seen, dropped_merges);
        $display("summary: %0d result terms checked, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("timeout with %0d result terms outstanding", expected_sum_terms.size());
        $display("tb: failure");
        $finish;
    end

endmodule
